/* rtl/gvm_pkg.sv */
package gvm_pkg;

    localparam int GRAD_W      = 32;
    localparam int CFG_W       = 32;
    localparam int STRAIN_W    = 38;
    localparam int STRESS_W    = 48;
    localparam int VM_W        = 47;
    localparam int SUMSQ_W     = 100;
    localparam int ROOT_W      = SUMSQ_W / 2;

    localparam int LAT_STRAIN  = 2;
    localparam int LAT_STIFF   = 2;
    localparam int LAT_VMSUM   = 3;
    localparam int LAT_SQRT    = ROOT_W;
    localparam int LATENCY     = LAT_STRAIN + LAT_STIFF + LAT_VMSUM + LAT_SQRT + 1;

    localparam logic [1:0] REG_DIM_MODE      = 2'd0;
    localparam logic [1:0] REG_LAME_LAMBDA   = 2'd1;
    localparam logic [1:0] REG_SHEAR_MODULUS = 2'd2;

    // row/column pairs of the six symmetric strain entries: 00 11 22 01 02 12
    localparam int SYM_I [6] = '{0, 1, 2, 0, 0, 1};
    localparam int SYM_J [6] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic signed [STRAIN_W-1:0] e00;
        logic signed [STRAIN_W-1:0] e11;
        logic signed [STRAIN_W-1:0] e22;
        logic signed [STRAIN_W-1:0] e01;
        logic signed [STRAIN_W-1:0] e02;
        logic signed [STRAIN_W-1:0] e12;
    } sym_t;

    typedef struct packed {
        logic signed [STRESS_W-1:0] xx;
        logic signed [STRESS_W-1:0] yy;
        logic signed [STRESS_W-1:0] zz;
        logic signed [STRESS_W-1:0] yz;
        logic signed [STRESS_W-1:0] xz;
        logic signed [STRESS_W-1:0] xy;
    } stress_t;

endpackage

/* rtl/gvm_strain.sv */
module gvm_strain (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              dim3,
    input  logic [8:0][gvm_pkg::GRAD_W-1:0]   grad,
    output logic                              out_valid,
    output gvm_pkg::sym_t                     strain
);
    import gvm_pkg::*;

    logic signed [GRAD_W-1:0]     g         [3][3];
    logic signed [2*GRAD_W-1:0]   prod_next [6][3];
    logic signed [2*GRAD_W-1:0]   prod_reg  [6][3];
    logic signed [GRAD_W:0]       lin_next  [6];
    logic signed [GRAD_W:0]       lin_reg   [6];
    logic signed [STRAIN_W-1:0]   s_next    [6];
    logic                         v1_reg;
    logic                         v2_reg;
    sym_t                         strain_reg;
    sym_t                         strain_next;

    // plane mode: row 2 and column 2 read as zero
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                g[r][c] = (dim3 || (r < 2 && c < 2)) ? $signed(grad[r*3+c]) : '0;
            end
        end
        for (int n = 0; n < 6; n++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[n][k] = g[k][SYM_I[n]] * g[k][SYM_J[n]];
            end
            lin_next[n] = (GRAD_W+1)'(g[SYM_I[n]][SYM_J[n]])
                        + (GRAD_W+1)'(g[SYM_J[n]][SYM_I[n]]);
        end
    end

    always_comb
    begin
        for (int n = 0; n < 6; n++)
        begin
            s_next[n] = STRAIN_W'(prod_reg[n][0] >>> 28)
                      + STRAIN_W'(prod_reg[n][1] >>> 28)
                      + STRAIN_W'(prod_reg[n][2] >>> 28)
                      + STRAIN_W'(lin_reg[n]);
        end
        strain_next = '{e00: s_next[0], e11: s_next[1], e22: s_next[2],
                        e01: s_next[3], e02: s_next[4], e12: s_next[5]};
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 6; n++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[n][k] <= prod_next[n][k];
            end
            lin_reg[n] <= lin_next[n];
        end
        strain_reg <= strain_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign strain    = strain_reg;

endmodule

/* rtl/gvm_stiff.sv */
module gvm_stiff (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              dim3,
    input  logic signed [gvm_pkg::CFG_W-1:0]  lame_lambda,
    input  logic signed [gvm_pkg::CFG_W-1:0]  shear_modulus,
    input  gvm_pkg::sym_t                     strain,
    output logic                              out_valid,
    output gvm_pkg::stress_t                  stress
);
    import gvm_pkg::*;

    localparam int C_W  = CFG_W + 2;
    localparam int E_W  = STRAIN_W + 1;
    localparam int EH_W = E_W - 13;
    localparam int P_W  = C_W + E_W + 4;

    logic signed [C_W-1:0]        cd;
    logic signed [C_W-1:0]        la;
    logic signed [C_W-1:0]        mu;
    logic signed [E_W-1:0]        e      [6];
    logic signed [C_W-1:0]        coef   [9];
    logic signed [E_W-1:0]        eop    [9];
    logic signed [C_W+EH_W-1:0]   ph_next [9];
    logic signed [C_W+EH_W-1:0]   ph_reg  [9];
    logic signed [C_W+13:0]       pl_next [9];
    logic signed [C_W+13:0]       pl_reg  [9];
    logic signed [P_W-1:0]        p      [9];
    logic signed [P_W-1:0]        sum_xx;
    logic signed [P_W-1:0]        sum_yy;
    logic signed [P_W-1:0]        sum_zz;
    logic                         dim3_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    stress_t                      stress_reg;
    stress_t                      stress_next;

    assign la = C_W'(lame_lambda);
    assign mu = C_W'(shear_modulus);
    assign cd = (mu <<< 1) + la;

    // Voigt strain: normal entries as they are, shear entries doubled
    always_comb
    begin
        e[0] = E_W'(strain.e00);
        e[1] = E_W'(strain.e11);
        e[2] = E_W'(strain.e22);
        e[3] = $signed({strain.e12, 1'b0});
        e[4] = $signed({strain.e02, 1'b0});
        e[5] = $signed({strain.e01, 1'b0});
        for (int k = 0; k < 3; k++)
        begin
            coef[2*k]   = cd;
            eop[2*k]    = e[k];
            coef[2*k+1] = la;
            eop[2*k+1]  = e[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            coef[6+k] = mu;
            eop[6+k]  = e[3+k];
        end
        // each product split at bit 13 of the strain
        for (int m = 0; m < 9; m++)
        begin
            ph_next[m] = coef[m] * EH_W'(eop[m] >>> 13);
            pl_next[m] = coef[m] * $signed({1'b0, eop[m][12:0]});
        end
    end

    always_comb
    begin
        for (int m = 0; m < 9; m++)
        begin
            p[m] = (P_W'(ph_reg[m]) <<< 13) + P_W'(pl_reg[m]);
        end
        sum_xx = p[0] + p[3] + p[5];
        sum_yy = p[1] + p[2] + p[5];
        sum_zz = p[1] + p[3] + p[4];
        stress_next.xx = STRESS_W'(sum_xx >>> 29);
        stress_next.yy = STRESS_W'(sum_yy >>> 29);
        stress_next.zz = dim3_reg ? STRESS_W'(sum_zz >>> 29) : '0;
        stress_next.yz = STRESS_W'(p[6] >>> 29);
        stress_next.xz = STRESS_W'(p[7] >>> 29);
        stress_next.xy = STRESS_W'(p[8] >>> 29);
    end

    always_ff @(posedge clk)
    begin
        for (int m = 0; m < 9; m++)
        begin
            ph_reg[m] <= ph_next[m];
            pl_reg[m] <= pl_next[m];
        end
        dim3_reg   <= dim3;
        stress_reg <= stress_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign stress    = stress_reg;

endmodule

/* rtl/gvm_vmsum.sv */
module gvm_vmsum (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             dim3,
    input  gvm_pkg::stress_t                 stress,
    output logic                             out_valid,
    output gvm_pkg::stress_t                 stress_out,
    output logic [gvm_pkg::SUMSQ_W-1:0]      sumsq
);
    import gvm_pkg::*;

    localparam int D_W  = STRESS_W + 1;
    localparam int LO_W = 24;
    localparam int HI_W = D_W - LO_W;
    localparam int SQ_W = 2 * D_W;
    localparam int T_W  = SUMSQ_W + 1;

    logic signed [D_W-1:0]        d       [6];
    logic [D_W-1:0]               mag     [6];
    logic [2*HI_W-1:0]            hh_next [6];
    logic [2*HI_W-1:0]            hh_reg  [6];
    logic [HI_W+LO_W-1:0]         hl_next [6];
    logic [HI_W+LO_W-1:0]         hl_reg  [6];
    logic [2*LO_W-1:0]            ll_next [6];
    logic [2*LO_W-1:0]            ll_reg  [6];
    logic [SQ_W-1:0]              sq_next [6];
    logic [SQ_W-1:0]              sq_reg  [6];
    logic [T_W-1:0]               t_sum;
    logic [SUMSQ_W-1:0]           sumsq_reg;
    logic                         dim3_1_reg;
    logic                         dim3_2_reg;
    stress_t                      st1_reg;
    stress_t                      st2_reg;
    stress_t                      st3_reg;
    logic [2:0]                   v_reg;

    always_comb
    begin
        d[0] = D_W'(stress.xx) - D_W'(stress.yy);
        d[1] = D_W'(stress.zz) - D_W'(stress.yy);
        d[2] = D_W'(stress.zz) - D_W'(stress.xx);
        d[3] = D_W'(stress.yz);
        d[4] = D_W'(stress.xz);
        d[5] = D_W'(stress.xy);
        for (int n = 0; n < 6; n++)
        begin
            mag[n]     = d[n][D_W-1] ? (~d[n] + 1'b1) : d[n];
            hh_next[n] = mag[n][D_W-1:LO_W] * mag[n][D_W-1:LO_W];
            hl_next[n] = mag[n][D_W-1:LO_W] * mag[n][LO_W-1:0];
            ll_next[n] = mag[n][LO_W-1:0] * mag[n][LO_W-1:0];
        end
    end

    always_comb
    begin
        for (int n = 0; n < 6; n++)
        begin
            sq_next[n] = (SQ_W'(hh_reg[n]) << (2*LO_W))
                       + (SQ_W'(hl_reg[n]) << (LO_W+1))
                       + SQ_W'(ll_reg[n]);
        end
        // (xx-yy)^2 + 6 xy^2, and in 3D the zz and out-of-plane shear terms
        t_sum = T_W'(sq_reg[0]) + (T_W'(sq_reg[5]) << 2) + (T_W'(sq_reg[5]) << 1);
        if (dim3_2_reg)
        begin
            t_sum = t_sum + T_W'(sq_reg[1]) + T_W'(sq_reg[2])
                  + (T_W'(sq_reg[3]) << 2) + (T_W'(sq_reg[3]) << 1)
                  + (T_W'(sq_reg[4]) << 2) + (T_W'(sq_reg[4]) << 1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 6; n++)
        begin
            hh_reg[n] <= hh_next[n];
            hl_reg[n] <= hl_next[n];
            ll_reg[n] <= ll_next[n];
            sq_reg[n] <= sq_next[n];
        end
        sumsq_reg  <= t_sum[T_W-1:1];
        dim3_1_reg <= dim3;
        dim3_2_reg <= dim3_1_reg;
        st1_reg    <= stress;
        st2_reg    <= st1_reg;
        st3_reg    <= st2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    assign out_valid  = v_reg[2];
    assign stress_out = st3_reg;
    assign sumsq      = sumsq_reg;

endmodule

/* rtl/gvm_sqrt.sv */
module gvm_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  gvm_pkg::stress_t                 stress,
    input  logic [gvm_pkg::SUMSQ_W-1:0]      sumsq,
    output logic                             out_valid,
    output gvm_pkg::stress_t                 stress_out,
    output logic [gvm_pkg::ROOT_W-1:0]       root
);
    import gvm_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]     rem_in    [ROOT_W];
    logic [ROOT_W-1:0]    root_in   [ROOT_W];
    logic [SUMSQ_W-1:0]   x_in      [ROOT_W];
    logic [REM_W+1:0]     rem_sh    [ROOT_W];
    logic [REM_W+1:0]     trial     [ROOT_W];
    logic                 take      [ROOT_W];
    logic [REM_W-1:0]     rem_next  [ROOT_W];
    logic [ROOT_W-1:0]    root_next [ROOT_W];
    logic [REM_W-1:0]     rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]    root_reg  [ROOT_W];
    logic [SUMSQ_W-1:0]   x_reg     [ROOT_W];
    stress_t              st_reg    [ROOT_W];
    logic [ROOT_W-1:0]    v_reg;

    // one root bit per stage, two radicand bits shifted in each time
    always_comb
    begin
        for (int i = 0; i < ROOT_W; i++)
        begin
            if (i == 0)
            begin
                rem_in[i]  = '0;
                root_in[i] = '0;
                x_in[i]    = sumsq;
            end
            else
            begin
                rem_in[i]  = rem_reg[i-1];
                root_in[i] = root_reg[i-1];
                x_in[i]    = x_reg[i-1];
            end
            rem_sh[i]    = {rem_in[i], x_in[i][SUMSQ_W-1:SUMSQ_W-2]};
            trial[i]     = {2'b00, root_in[i], 2'b01};
            take[i]      = rem_sh[i] >= trial[i];
            rem_next[i]  = take[i] ? REM_W'(rem_sh[i] - trial[i]) : rem_sh[i][REM_W-1:0];
            root_next[i] = {root_in[i][ROOT_W-2:0], take[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ROOT_W; i++)
        begin
            rem_reg[i]  <= rem_next[i];
            root_reg[i] <= root_next[i];
            x_reg[i]    <= {x_in[i][SUMSQ_W-3:0], 2'b00};
            st_reg[i]   <= (i == 0) ? stress : st_reg[(i == 0) ? 0 : i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[ROOT_W-2:0], in_valid};
        end
    end

    assign out_valid  = v_reg[ROOT_W-1];
    assign stress_out = st_reg[ROOT_W-1];
    assign root       = root_reg[ROOT_W-1];

endmodule

/* rtl/green_strain_von_mises_stress.sv */
// Saint Venant-Kirchhoff stress and von Mises value for one displacement gradient.
// Input: nine Q4.28 gradient words, taken at each clock edge where start is high
// and busy is low. busy stays low: a new word can be issued every cycle.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
// 0 dimension_mode, 1 lame_lambda, 2 shear_modulus; index 3 is ignored.
// cfg_ready is always high. Write registers only with the pipeline empty.
// Output: result_valid marks the six Q32.16 stresses and the von Mises value
// for exactly one cycle; there is no back-pressure.
// Pipeline: one result per cycle. The square root has 50 stages,
// one root bit each, behind 2 strain, 2 stiffness and 3 square-sum stages
// plus the output register.
// Reset empties the pipeline and restores 3D mode with lambda and mu at zero.
module green_strain_von_mises_stress (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [gvm_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [gvm_pkg::GRAD_W-1:0]   grad_r0_c0,
    input  logic signed [gvm_pkg::GRAD_W-1:0]   grad_r0_c1,
    input  logic signed [gvm_pkg::GRAD_W-1:0]   grad_r0_c2,
    input  logic signed [gvm_pkg::GRAD_W-1:0]   grad_r1_c0,
    input  logic signed [gvm_pkg::GRAD_W-1:0]   grad_r1_c1,
    input  logic signed [gvm_pkg::GRAD_W-1:0]   grad_r1_c2,
    input  logic signed [gvm_pkg::GRAD_W-1:0]   grad_r2_c0,
    input  logic signed [gvm_pkg::GRAD_W-1:0]   grad_r2_c1,
    input  logic signed [gvm_pkg::GRAD_W-1:0]   grad_r2_c2,
    output logic                                result_valid,
    output logic signed [gvm_pkg::STRESS_W-1:0] stress_xx,
    output logic signed [gvm_pkg::STRESS_W-1:0] stress_yy,
    output logic signed [gvm_pkg::STRESS_W-1:0] stress_zz,
    output logic signed [gvm_pkg::STRESS_W-1:0] stress_yz,
    output logic signed [gvm_pkg::STRESS_W-1:0] stress_xz,
    output logic signed [gvm_pkg::STRESS_W-1:0] stress_xy,
    output logic [gvm_pkg::VM_W-1:0]            von_mises
);
    import gvm_pkg::*;

    logic                       dim_mode_reg;
    logic signed [CFG_W-1:0]    lambda_reg;
    logic signed [CFG_W-1:0]    mu_reg;
    logic [8:0][GRAD_W-1:0]     grad;
    logic                       accept;
    logic                       strain_valid;
    sym_t                       strain;
    logic                       stiff_valid;
    stress_t                    stress_a;
    logic                       sum_valid;
    stress_t                    stress_b;
    logic [SUMSQ_W-1:0]         sumsq;
    logic                       root_valid;
    stress_t                    stress_c;
    logic [ROOT_W-1:0]          root;
    logic                       valid_reg;
    stress_t                    out_reg;
    logic [VM_W-1:0]            vm_reg;
    logic [VM_W-1:0]            vm_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign grad = {grad_r2_c2, grad_r2_c1, grad_r2_c0,
                   grad_r1_c2, grad_r1_c1, grad_r1_c0,
                   grad_r0_c2, grad_r0_c1, grad_r0_c0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_mode_reg <= 1'b1;
            lambda_reg   <= '0;
            mu_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DIM_MODE:      dim_mode_reg <= cfg_data[0];
                REG_LAME_LAMBDA:   lambda_reg   <= $signed(cfg_data);
                REG_SHEAR_MODULUS: mu_reg       <= $signed(cfg_data);
                default:           ;
            endcase
        end
    end

    gvm_strain u_strain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .dim3      (dim_mode_reg),
        .grad      (grad),
        .out_valid (strain_valid),
        .strain    (strain)
    );

    gvm_stiff u_stiff (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (strain_valid),
        .dim3          (dim_mode_reg),
        .lame_lambda   (lambda_reg),
        .shear_modulus (mu_reg),
        .strain        (strain),
        .out_valid     (stiff_valid),
        .stress        (stress_a)
    );

    gvm_vmsum u_vmsum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stiff_valid),
        .dim3       (dim_mode_reg),
        .stress     (stress_a),
        .out_valid  (sum_valid),
        .stress_out (stress_b),
        .sumsq      (sumsq)
    );

    gvm_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sum_valid),
        .stress     (stress_b),
        .sumsq      (sumsq),
        .out_valid  (root_valid),
        .stress_out (stress_c),
        .root       (root)
    );

    // saturate the root to the 47 bit result range
    assign vm_next = (|root[ROOT_W-1:VM_W]) ? {VM_W{1'b1}} : root[VM_W-1:0];

    always_ff @(posedge clk)
    begin
        out_reg <= stress_c;
        vm_reg  <= vm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= root_valid;
        end
    end

    assign result_valid = valid_reg;
    assign stress_xx    = out_reg.xx;
    assign stress_yy    = out_reg.yy;
    assign stress_zz    = out_reg.zz;
    assign stress_yz    = out_reg.yz;
    assign stress_xz    = out_reg.xz;
    assign stress_xy    = out_reg.xy;
    assign von_mises    = vm_reg;

endmodule

/* rtl/gvm_checker.sv */
module gvm_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic cfg_ready,
    input  logic result_valid
);
    import gvm_pkg::*;

    a_word_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("accepted word gave no result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching word");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("pipeline refused a word");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind green_strain_von_mises_stress gvm_checker u_gvm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid)
);

/* test/tb_green_strain_von_mises_stress.sv */
module tb_green_strain_von_mises_stress;
    timeunit 1ns;
    timeprecision 1ps;
    import gvm_pkg::*;

    localparam int WATCHDOG = 4000;

    typedef struct {
        logic signed [STRESS_W-1:0] xx;
        logic signed [STRESS_W-1:0] yy;
        logic signed [STRESS_W-1:0] zz;
        logic signed [STRESS_W-1:0] yz;
        logic signed [STRESS_W-1:0] xz;
        logic signed [STRESS_W-1:0] xy;
        logic [VM_W-1:0]            vm;
    } stress_word_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic signed [GRAD_W-1:0] g [9];
    logic result_valid;
    logic signed [STRESS_W-1:0] stress_xx, stress_yy, stress_zz;
    logic signed [STRESS_W-1:0] stress_yz, stress_xz, stress_xy;
    logic [VM_W-1:0] von_mises;

    // model copy of the registers
    logic mode_3d;
    logic signed [31:0] lam;
    logic signed [31:0] mu;

    stress_word_t expected_stress [$];
    int errors;
    int sent;
    int received;
    int idle_cycles;
    int n2d;
    int n3d;
    bit gaps_on;

    green_strain_von_mises_stress dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .grad_r0_c0(g[0]), .grad_r0_c1(g[1]), .grad_r0_c2(g[2]),
        .grad_r1_c0(g[3]), .grad_r1_c1(g[4]), .grad_r1_c2(g[5]),
        .grad_r2_c0(g[6]), .grad_r2_c1(g[7]), .grad_r2_c2(g[8]),
        .result_valid(result_valid),
        .stress_xx(stress_xx), .stress_yy(stress_yy), .stress_zz(stress_zz),
        .stress_yz(stress_yz), .stress_xz(stress_xz), .stress_xy(stress_xy),
        .von_mises(von_mises)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [STRESS_W-1:0] clamp48(logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (STRESS_W - 1)) - 1;
        lo = -(128'sd1 <<< (STRESS_W - 1));
        if (v > hi)
            return hi[STRESS_W-1:0];
        if (v < lo)
            return lo[STRESS_W-1:0];
        return v[STRESS_W-1:0];
    endfunction

    function automatic stress_word_t svk_stress(logic signed [GRAD_W-1:0] gr [9]);
        stress_word_t r;
        logic signed [127:0] s [3][3];
        logic signed [127:0] p;
        logic signed [127:0] cd;
        logic signed [127:0] d;
        logic [127:0] t;
        logic [127:0] root;
        logic [127:0] c;
        int n;
        n = mode_3d ? 3 : 2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                s[i][j] = 0;
                if (i < n && j < n)
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        p = 128'(gr[k*3+i]) * 128'(gr[k*3+j]);
                        s[i][j] += p >>> 28;
                    end
                    s[i][j] += 128'(gr[i*3+j]) + 128'(gr[j*3+i]);
                end
            end
        cd = 2 * 128'(mu) + 128'(lam);
        // strain carries 29 fraction bits: shear doubled, normal taken raw
        r.xx = clamp48((cd * s[0][0] + lam * s[1][1] + lam * s[2][2]) >>> 29);
        r.yy = clamp48((lam * s[0][0] + cd * s[1][1] + lam * s[2][2]) >>> 29);
        r.xy = clamp48((128'(mu) * 2 * s[0][1]) >>> 29);
        if (mode_3d)
        begin
            r.zz = clamp48((lam * s[0][0] + lam * s[1][1] + cd * s[2][2]) >>> 29);
            r.yz = clamp48((128'(mu) * 2 * s[1][2]) >>> 29);
            r.xz = clamp48((128'(mu) * 2 * s[0][2]) >>> 29);
        end
        else
        begin
            r.zz = '0;
            r.yz = '0;
            r.xz = '0;
        end
        d = 128'(r.xx) - 128'(r.yy);
        t = d * d + 6 * 128'(r.xy) * 128'(r.xy);
        if (mode_3d)
        begin
            d = 128'(r.zz) - 128'(r.yy);
            t += d * d;
            d = 128'(r.zz) - 128'(r.xx);
            t += d * d;
            t += 6 * (128'(r.yz) * 128'(r.yz) + 128'(r.xz) * 128'(r.xz));
        end
        t = t >> 1;
        root = 0;
        for (int b = 55; b >= 0; b--)
        begin
            c = root | (128'd1 << b);
            if (c * c <= t)
                root = c;
        end
        if (root > ((128'd1 << VM_W) - 1))
            root = (128'd1 << VM_W) - 1;
        r.vm = root[VM_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch on word %0d, %s: got %h expected %h", received, what, got, want);
    endtask

    task automatic idle_burst();
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // start stays high between back-to-back words; idle_burst and drain drop it
    task automatic send_grad(logic signed [GRAD_W-1:0] gr [9]);
        idle_burst();
        for (int i = 0; i < 9; i++)
            g[i] <= gr[i];
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_stress.push_back(svk_stress(gr));
        if (mode_3d)
            n3d++;
        else
            n2d++;
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_stress.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_DIM_MODE)
            mode_3d = val[0];
        else if (idx == REG_LAME_LAMBDA)
            lam = val;
        else if (idx == REG_SHEAR_MODULUS)
            mu = val;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_grad(int kind);
        case (kind)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
        endcase
    endfunction

    task automatic test_directed();
        logic signed [GRAD_W-1:0] gr [9];
        // reset values: lambda and mu zero, 3D
        for (int i = 0; i < 9; i++)
            gr[i] = 32'h1000_0000;
        send_grad(gr);
        drain();
        write_reg(REG_LAME_LAMBDA, 32'h0001_8000);
        write_reg(REG_SHEAR_MODULUS, 32'h0000_c000);
        write_reg(2'd3, 32'hffff_ffff);
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 9; i++)
                gr[i] = k == 0 ? 32'h8000_0000 : k == 1 ? 32'h7fff_ffff :
                        k == 2 ? 32'h0 : 32'(i) << 26;
            send_grad(gr);
        end
        gr[0] = 32'h0400_0000; gr[1] = 32'hfc00_0000;
        send_grad(gr);
        drain();
        write_reg(REG_DIM_MODE, 32'hffff_fffe);
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 9; i++)
                gr[i] = k == 0 ? 32'h8000_0000 : k == 1 ? 32'h7fff_ffff : $urandom;
            send_grad(gr);
        end
        drain();
        // saturating stiffness extremes
        write_reg(REG_LAME_LAMBDA, 32'h7fff_ffff);
        write_reg(REG_SHEAR_MODULUS, 32'h8000_0000);
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 9; i++)
                gr[i] = rand_grad(k);
            send_grad(gr);
        end
        drain();
        write_reg(REG_DIM_MODE, 32'h1);
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 9; i++)
                gr[i] = rand_grad(k);
            send_grad(gr);
        end
        drain();
    endtask

    task automatic test_random(int count);
        logic signed [GRAD_W-1:0] gr [9];
        int kind;
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_DIM_MODE, $urandom);
            write_reg(REG_LAME_LAMBDA, phase == 0 ? 32'h8000_0000 :
                      phase == 1 ? 32'h7fff_ffff : $urandom_range(0, 1) ?
                      $urandom : 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20)));
            write_reg(REG_SHEAR_MODULUS, phase == 1 ? 32'h8000_0000 :
                      phase == 0 ? 32'h7fff_ffff : $urandom_range(0, 1) ?
                      $urandom : 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20)));
            for (int n = 0; n < count / 8; n++)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    kind = $urandom_range(0, 9);
                    gr[i] = rand_grad(kind < 1 ? 0 : kind < 2 ? 1 : kind < 5 ? 2 : 3);
                end
                send_grad(gr);
            end
            drain();
        end
    endtask

    task automatic test_back_to_back(int count);
        logic signed [GRAD_W-1:0] gr [9];
        gaps_on = 0;
        write_reg(REG_DIM_MODE, 32'h1);
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 9; i++)
                gr[i] = rand_grad($urandom_range(2, 3));
            send_grad(gr);
        end
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        stress_word_t w;
        if (rst_n && result_valid)
        begin
            if (expected_stress.size() == 0)
            begin
                errors++;
                $display("result word with nothing expected");
            end
            else
            begin
                w = expected_stress.pop_front();
                if (stress_xx !== w.xx) report_mismatch("xx", 64'(stress_xx), 64'(w.xx));
                if (stress_yy !== w.yy) report_mismatch("yy", 64'(stress_yy), 64'(w.yy));
                if (stress_zz !== w.zz) report_mismatch("zz", 64'(stress_zz), 64'(w.zz));
                if (stress_yz !== w.yz) report_mismatch("yz", 64'(stress_yz), 64'(w.yz));
                if (stress_xz !== w.xz) report_mismatch("xz", 64'(stress_xz), 64'(w.xz));
                if (stress_xy !== w.xy) report_mismatch("xy", 64'(stress_xy), 64'(w.xy));
                if (von_mises !== w.vm) report_mismatch("vm", 64'(von_mises), 64'(w.vm));
            end
            received++;
        end
    end

    // watchdog: cycles without any accepted word, result or configuration write
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("tb_green_strain_von_mises_stress: errors");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        sent = 0;
        received = 0;
        idle_cycles = 0;
        n2d = 0;
        n3d = 0;
        gaps_on = 1;
        mode_3d = 1'b1;
        lam = '0;
        mu = '0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 9; i++)
            g[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1600);
        test_back_to_back(400);
        $display("sent %0d gradients (%0d plane, %0d 3D), checked %0d results",
                 sent, n2d, n3d, received);
        if (errors == 0 && expected_stress.size() == 0)
            $display("tb_green_strain_von_mises_stress: clean");
        else
            $display("tb_green_strain_von_mises_stress: errors");
        $finish;
    end
endmodule

/* filelist.f */
rtl/gvm_pkg.sv
rtl/gvm_strain.sv
rtl/gvm_stiff.sv
rtl/gvm_vmsum.sv
rtl/gvm_sqrt.sv
rtl/green_strain_von_mises_stress.sv
rtl/gvm_checker.sv
test/tb_green_strain_von_mises_stress.sv
